// ===== rtl/clt_pkg.sv =====
package clt_pkg;

   // expander bit positions of the control lines (data nibble sits in bits 3..0)
   localparam logic [2:0] RS_BIT        = 3'd4;
   localparam logic [2:0] ENABLE_BIT    = 3'd6;
   localparam logic [2:0] BACKLIGHT_BIT = 3'd7;

   // display geometry limits
   localparam logic [5:0] MAX_COLUMNS = 6'd40;
   localparam logic [2:0] ROW_LIMIT   = 3'd4;

   // character codes
   localparam logic [7:0] CODE_NEWLINE = 8'd10;
   localparam logic [7:0] CODE_RETURN  = 8'd13;
   localparam logic [7:0] CODE_LOWEST  = 8'd10;
   localparam logic [7:0] CODE_HIGHEST = 8'd127;

   // LCD commands
   localparam logic [7:0] CMD_SET_ADDRESS = 8'h80;
   localparam logic [7:0] CMD_CLEAR       = 8'h01;
   localparam logic [7:0] CMD_HOME        = 8'h02;

   // configuration register indexes
   localparam logic [2:0] CSR_COLUMNS_IN_USE    = 3'd0;
   localparam logic [2:0] CSR_ROWS_IN_USE       = 3'd1;
   localparam logic [2:0] CSR_ROW_ONE_ADDRESS   = 3'd2;
   localparam logic [2:0] CSR_ROW_TWO_ADDRESS   = 3'd3;
   localparam logic [2:0] CSR_ROW_THREE_ADDRESS = 3'd4;
   localparam logic [2:0] CSR_ROW_FOUR_ADDRESS  = 3'd5;
   localparam logic [2:0] CSR_BACKLIGHT_ON      = 3'd6;

   // geometry settings seen by the decoder
   typedef struct packed {
      logic [5:0] columns;
      logic [2:0] rows;
      logic [6:0] row_addr0;
      logic [6:0] row_addr1;
      logic [6:0] row_addr2;
      logic [6:0] row_addr3;
   } clt_cfg_type;

   // one or two LCD bytes to send for a character
   typedef struct packed {
      logic       two_bytes;
      logic [7:0] byte0;
      logic       rs0;
      logic [7:0] byte1;
      logic       rs1;
   } clt_plan_type;

endpackage

// ===== rtl/clt_decode.sv =====
module clt_decode
   import clt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_char_code,
   input  clt_cfg_type  cfg,
   output logic         plan_valid,
   output clt_plan_type plan,
   input  logic         plan_take
);

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_char_ff;
   logic [2:0]   cursor_row_ff, cursor_row_in;
   logic [5:0]   cursor_column_ff, cursor_column_in;
   logic         accept, in_take, drop;
   logic [2:0]   rows_eff, next_row;
   logic [5:0]   cols_eff;
   logic [6:0]   cur_addr, next_addr;
   clt_plan_type plan_c;

   function automatic logic [6:0] row_start(input clt_cfg_type c, input logic [1:0] row);
      logic [6:0] a;
      case (row)
         2'd0:    a = c.row_addr0;
         2'd1:    a = c.row_addr1;
         2'd2:    a = c.row_addr2;
         default: a = c.row_addr3;
      endcase
      return a;
   endfunction

   // character decode: what to send and where the cursor goes
   always_comb begin
      rows_eff         = (cfg.rows > ROW_LIMIT) ? ROW_LIMIT : cfg.rows;
      cols_eff         = (cfg.columns > MAX_COLUMNS) ? MAX_COLUMNS : cfg.columns;
      next_row         = cursor_row_ff + 3'd1;
      cur_addr         = row_start(cfg, cursor_row_ff[1:0]);
      next_addr        = row_start(cfg, next_row[1:0]);
      drop             = 1'b1;
      plan_c           = '0;
      cursor_row_in    = cursor_row_ff;
      cursor_column_in = cursor_column_ff;
      if (in_char_ff >= CODE_LOWEST && in_char_ff <= CODE_HIGHEST) begin
         drop = 1'b0;
         if (in_char_ff == CODE_RETURN) begin
            plan_c.byte0     = CMD_SET_ADDRESS | {1'b0, cur_addr};
            cursor_row_in    = {1'b0, cursor_row_ff[1:0]};
            cursor_column_in = 6'd0;
         end else if (in_char_ff == CODE_NEWLINE) begin
            if (next_row < rows_eff) begin
               plan_c.byte0  = CMD_SET_ADDRESS | {1'b0, next_addr};
               cursor_row_in = {1'b0, next_row[1:0]};
            end else begin
               plan_c.two_bytes = 1'b1;
               plan_c.byte0     = CMD_CLEAR;
               plan_c.byte1     = CMD_HOME;
               cursor_row_in    = 3'd0;
            end
            cursor_column_in = 6'd0;
         end else if (cursor_column_ff < cols_eff) begin
            plan_c.byte0     = in_char_ff;
            plan_c.rs0       = 1'b1;
            cursor_column_in = cursor_column_ff + 6'd1;
         end else if (next_row < rows_eff) begin
            // wrap onto the next row and write there
            plan_c.two_bytes = 1'b1;
            plan_c.byte0     = CMD_SET_ADDRESS | {1'b0, next_addr};
            plan_c.byte1     = in_char_ff;
            plan_c.rs1       = 1'b1;
            cursor_row_in    = {1'b0, next_row[1:0]};
            cursor_column_in = 6'd1;
         end else begin
            // past the last row: clear, character is lost
            plan_c.two_bytes = 1'b1;
            plan_c.byte0     = CMD_CLEAR;
            plan_c.byte1     = CMD_HOME;
            cursor_row_in    = 3'd0;
            cursor_column_in = 6'd0;
         end
      end
   end

   // input word handshake
   assign in_take    = in_valid_ff && (drop || plan_take);
   assign req_stall  = in_valid_ff && !in_take;
   assign accept     = req_valid && !req_stall;
   assign plan_valid = in_valid_ff && !drop;
   assign plan       = plan_c;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (in_take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         cursor_row_ff    <= 3'd0;
         cursor_column_ff <= 6'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (in_take) begin
            cursor_row_ff    <= cursor_row_in;
            cursor_column_ff <= cursor_column_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_char_code;
      end
   end

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      cursor_row_ff < ROW_LIMIT)
      else $error("cursor row out of range");

   a_column_range: assert property (@(posedge clock) disable iff (reset)
      cursor_column_ff <= MAX_COLUMNS)
      else $error("cursor column out of range");

   a_return_homes_column: assert property (@(posedge clock) disable iff (reset)
      in_take && !drop && in_char_ff == CODE_RETURN |=> cursor_column_ff == 6'd0)
      else $error("carriage return left column nonzero");

endmodule

// ===== rtl/clt_emit.sv =====
module clt_emit
   import clt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         backlight_on,
   input  logic         plan_valid,
   input  clt_plan_type plan,
   output logic         plan_take,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   rsp_expander_byte,
   output logic         rsp_transfer_start,
   output logic         rsp_transfer_end,
   output logic         rsp_last_of_run
);

   localparam logic [1:0] PH_SETUP  = 2'd0;
   localparam logic [1:0] PH_STROBE = 2'd1;
   localparam logic [1:0] PH_LATCH  = 2'd2;

   clt_plan_type work_ff;
   logic         work_valid_ff, work_valid_in;
   logic [1:0]   phase_ff, phase_in;
   logic         nib_ff, nib_in;
   logic         sel_ff, sel_in;
   logic [7:0]   shadow_ff, step_byte;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   byte_ff;
   logic         start_ff, end_ff, last_ff;
   logic         emit, last_step, cur_rs;
   logic [7:0]   cur_lcd;
   logic [3:0]   cur_nib;

   assign emit      = work_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign last_step = (phase_ff == PH_LATCH) && nib_ff && (sel_ff || !work_ff.two_bytes);
   assign plan_take = plan_valid && (!work_valid_ff || (emit && last_step));

   // current LCD byte and nibble
   assign cur_lcd = sel_ff ? work_ff.byte1 : work_ff.byte0;
   assign cur_rs  = sel_ff ? work_ff.rs1 : work_ff.rs0;
   assign cur_nib = nib_ff ? cur_lcd[3:0] : cur_lcd[7:4];

   // next expander byte from the shadow
   always_comb begin
      step_byte = shadow_ff;
      case (phase_ff)
         PH_SETUP: begin
            if (!nib_ff) begin
               step_byte[RS_BIT] = cur_rs;
            end
            step_byte[3:0]           = cur_nib;
            step_byte[BACKLIGHT_BIT] = ~backlight_on;
            step_byte[ENABLE_BIT]    = 1'b0;
         end
         PH_STROBE: step_byte[ENABLE_BIT] = 1'b1;
         default:   step_byte[ENABLE_BIT] = 1'b0;
      endcase
   end

   // step counters: phase within nibble, nibble within byte, byte within run
   always_comb begin
      phase_in      = phase_ff;
      nib_in        = nib_ff;
      sel_in        = sel_ff;
      work_valid_in = work_valid_ff;
      if (emit) begin
         if (phase_ff == PH_LATCH) begin
            phase_in = PH_SETUP;
            nib_in   = ~nib_ff;
            if (nib_ff) begin
               sel_in = ~sel_ff;
            end
            if (last_step) begin
               sel_in        = 1'b0;
               work_valid_in = 1'b0;
            end
         end else begin
            phase_in = phase_ff + 2'd1;
         end
      end
      if (plan_take) begin
         work_valid_in = 1'b1;
         phase_in      = PH_SETUP;
         nib_in        = 1'b0;
         sel_in        = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         phase_ff      <= PH_SETUP;
         nib_ff        <= 1'b0;
         sel_ff        <= 1'b0;
         shadow_ff     <= 8'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         phase_ff      <= phase_in;
         nib_ff        <= nib_in;
         sel_ff        <= sel_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (emit) begin
            shadow_ff <= step_byte;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (plan_take) begin
         work_ff <= plan;
      end
      if (emit) begin
         byte_ff  <= step_byte;
         start_ff <= (phase_ff == PH_SETUP);
         end_ff   <= (phase_ff == PH_LATCH);
         last_ff  <= last_step;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_expander_byte  = byte_ff;
   assign rsp_transfer_start = start_ff;
   assign rsp_transfer_end   = end_ff;
   assign rsp_last_of_run    = last_ff;

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("nibble phase out of range");

   a_last_ends_transfer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff |-> end_ff && !start_ff)
      else $error("last word of run is not a transfer end");

   a_strobe_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !start_ff && !end_ff |-> byte_ff[ENABLE_BIT])
      else $error("middle word of transfer without enable");

endmodule

// ===== rtl/char_lcd_terminal_writer.sv =====
// Character terminal for a 4-bit character LCD behind an 8-bit port expander.
// Each character word on req_ is turned into expander words on rsp_: nothing
// for codes 0..9 and 128..255, six words for a printable code, carriage return
// or a newline that stays on screen, and twelve words when a wrap addresses the
// next row or the screen is cleared. Every LCD byte goes out as two nibbles,
// each one bus transfer of three words (enable low, high, low) flagged by
// rsp_transfer_start/rsp_transfer_end; rsp_last_of_run marks the final word of
// a character. The output register sends one word per cycle unless rsp_stall
// holds it, and the next character is taken and decoded while the previous run
// drains. An accepted word goes through the decode input register and the
// work register to the output register. The user must set registers through
// csr_ only while the block is idle; the block itself does not enforce it.
module char_lcd_terminal_writer
   import clt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_expander_byte,
   output logic       rsp_transfer_start,
   output logic       rsp_transfer_end,
   output logic       rsp_last_of_run,
   input  logic       csr_write_enable,
   input  logic [2:0] csr_index,
   input  logic [6:0] csr_write_data
);

   clt_cfg_type  cfg_ff;
   logic         backlight_on_ff;
   logic         plan_valid, plan_take;
   clt_plan_type plan;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.columns   <= 6'd20;
         cfg_ff.rows      <= 3'd4;
         cfg_ff.row_addr0 <= 7'd0;
         cfg_ff.row_addr1 <= 7'd64;
         cfg_ff.row_addr2 <= 7'd20;
         cfg_ff.row_addr3 <= 7'd84;
         backlight_on_ff  <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_COLUMNS_IN_USE:    cfg_ff.columns   <= csr_write_data[5:0];
            CSR_ROWS_IN_USE:       cfg_ff.rows      <= csr_write_data[2:0];
            CSR_ROW_ONE_ADDRESS:   cfg_ff.row_addr0 <= csr_write_data;
            CSR_ROW_TWO_ADDRESS:   cfg_ff.row_addr1 <= csr_write_data;
            CSR_ROW_THREE_ADDRESS: cfg_ff.row_addr2 <= csr_write_data;
            CSR_ROW_FOUR_ADDRESS:  cfg_ff.row_addr3 <= csr_write_data;
            CSR_BACKLIGHT_ON:      backlight_on_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   clt_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .cfg           (cfg_ff),
      .plan_valid    (plan_valid),
      .plan          (plan),
      .plan_take     (plan_take)
   );

   clt_emit u_emit (
      .clock              (clock),
      .reset              (reset),
      .backlight_on       (backlight_on_ff),
      .plan_valid         (plan_valid),
      .plan               (plan),
      .plan_take          (plan_take),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_expander_byte  (rsp_expander_byte),
      .rsp_transfer_start (rsp_transfer_start),
      .rsp_transfer_end   (rsp_transfer_end),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule

// ===== verif/tb.sv =====
import clt_pkg::*;

// one expander word as seen on the result channel
typedef struct packed {
   logic [7:0] data;
   logic       start;
   logic       stop;
   logic       last;
} expander_word_type;

// Display terminal predictor plus the queue of expander words still owed
class terminal_scoreboard;
   // register copy
   logic [5:0] columns;
   logic [2:0] rows;
   logic [6:0] row_addr [4];
   logic       backlight;
   // display state
   logic [7:0] shadow;
   logic [2:0] cur_row;
   logic [5:0] cur_col;
   expander_word_type words_due [$];
   int errors;
   int chars_seen;
   int chars_shown;
   int words_seen;

   function new();
      columns     = 6'd20;
      rows        = 3'd4;
      row_addr[0] = 7'd0;
      row_addr[1] = 7'd64;
      row_addr[2] = 7'd20;
      row_addr[3] = 7'd84;
      backlight   = 1'b1;
      shadow      = 8'd0;
      cur_row     = 3'd0;
      cur_col     = 6'd0;
      errors      = 0;
      chars_seen  = 0;
      chars_shown = 0;
      words_seen  = 0;
   endfunction

   function void set_reg(logic [2:0] idx, logic [6:0] value);
      case (idx)
         CSR_COLUMNS_IN_USE:    columns = value[5:0];
         CSR_ROWS_IN_USE:       rows = value[2:0];
         CSR_ROW_ONE_ADDRESS:   row_addr[0] = value;
         CSR_ROW_TWO_ADDRESS:   row_addr[1] = value;
         CSR_ROW_THREE_ADDRESS: row_addr[2] = value;
         CSR_ROW_FOUR_ADDRESS:  row_addr[3] = value;
         CSR_BACKLIGHT_ON:      backlight = value[0];
         default: ;
      endcase
   endfunction

   function int pending();
      return words_due.size();
   endfunction

   function void put_word(logic start, logic stop);
      expander_word_type w;
      w.data  = shadow;
      w.start = start;
      w.stop  = stop;
      w.last  = 1'b0;
      words_due.push_back(w);
   endfunction

   // one bus transfer: enable low, high, low
   function void put_nibble(logic [3:0] nib);
      shadow[3:0]           = nib;
      shadow[BACKLIGHT_BIT] = ~backlight;  // backlight lit when the bit is low
      shadow[ENABLE_BIT]    = 1'b0;
      put_word(1'b1, 1'b0);
      shadow[ENABLE_BIT] = 1'b1;
      put_word(1'b0, 1'b0);
      shadow[ENABLE_BIT] = 1'b0;
      put_word(1'b0, 1'b1);
   endfunction

   function void put_lcd_byte(logic [7:0] value, logic is_data);
      shadow[RS_BIT] = is_data;
      put_nibble(value[7:4]);
      put_nibble(value[3:0]);
   endfunction

   function void go_row(logic [2:0] row);
      logic [1:0] r;
      r       = row[1:0];
      cur_row = {1'b0, r};
      cur_col = 6'd0;
      put_lcd_byte(CMD_SET_ADDRESS | {1'b0, row_addr[r]}, 1'b0);
   endfunction

   function void clear_home();
      put_lcd_byte(CMD_CLEAR, 1'b0);
      put_lcd_byte(CMD_HOME, 1'b0);
      cur_row = 3'd0;
      cur_col = 6'd0;
   endfunction

   // work out the expander words one accepted character causes
   function void note_char(logic [7:0] code);
      int         words_before;
      logic [2:0] row_lim;
      logic [5:0] col_lim;
      logic [3:0] next_row;
      words_before = words_due.size();
      chars_seen++;
      row_lim  = (rows > ROW_LIMIT) ? ROW_LIMIT : rows;
      col_lim  = (columns > MAX_COLUMNS) ? MAX_COLUMNS : columns;
      next_row = {1'b0, cur_row} + 4'd1;
      if (code < CODE_LOWEST || code > CODE_HIGHEST) return;
      chars_shown++;
      if (code == CODE_RETURN) begin
         go_row(cur_row);
      end else if (code == CODE_NEWLINE) begin
         if (next_row < {1'b0, row_lim}) go_row(next_row[2:0]);
         else clear_home();
      end else if (cur_col < col_lim) begin
         put_lcd_byte(code, 1'b1);
         cur_col = cur_col + 6'd1;
      end else if (next_row < {1'b0, row_lim}) begin
         // wrap onto the next row, then write
         go_row(next_row[2:0]);
         put_lcd_byte(code, 1'b1);
         cur_col = 6'd1;
      end else begin
         // past the last row: clear, character dropped
         clear_home();
      end
      if (words_due.size() > words_before) words_due[words_due.size() - 1].last = 1'b1;
   endfunction

   task report(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
   endtask

   task check_word(logic [7:0] data, logic start, logic stop, logic last);
      expander_word_type w;
      words_seen++;
      if (words_due.size() == 0) begin
         report($sformatf("word %0d (%02h) arrived with nothing owed", words_seen, data));
         return;
      end
      w = words_due.pop_front();
      if (data !== w.data)
         report($sformatf("word %0d: expander byte %02h, want %02h", words_seen, data, w.data));
      if (start !== w.start)
         report($sformatf("word %0d: transfer_start %b, want %b", words_seen, start, w.start));
      if (stop !== w.stop)
         report($sformatf("word %0d: transfer_end %b, want %b", words_seen, stop, w.stop));
      if (last !== w.last)
         report($sformatf("word %0d: last_of_run %b, want %b", words_seen, last, w.last));
   endtask
endclass

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CSR_UNUSED = 3'd7;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_code = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_expander_byte;
   logic       rsp_transfer_start;
   logic       rsp_transfer_end;
   logic       rsp_last_of_run;
   logic       csr_write_enable = 1'b0;
   logic [2:0] csr_index = 3'd0;
   logic [6:0] csr_write_data = 7'd0;

   terminal_scoreboard sb = new();
   bit calm = 1'b0;
   int stall_left = 0;
   int settings_used = 0;

   char_lcd_terminal_writer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_code      (req_char_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_expander_byte  (rsp_expander_byte),
      .rsp_transfer_start (rsp_transfer_start),
      .rsp_transfer_end   (rsp_transfer_end),
      .rsp_last_of_run    (rsp_last_of_run),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // idle length: mostly none or short, now and then long
   function int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // receiver stalls in bursts
   always @(negedge clock) begin : stall_gen
      int g;
      if (calm) begin
         rsp_stall  = 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if (rsp_stall) begin
         rsp_stall  = 1'b0;
         stall_left = $urandom_range(0, 15);
      end else begin
         g = pick_gap();
         if (g > 0) begin
            rsp_stall  = 1'b1;
            stall_left = g - 1;
         end else begin
            stall_left = $urandom_range(0, 15);
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word(rsp_expander_byte, rsp_transfer_start, rsp_transfer_end,
                       rsp_last_of_run);
   end

   task send_char(logic [7:0] code);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_char_code = code;
      do @(posedge clock); while (req_stall);
      sb.note_char(code);
   endtask

   // stop sending and wait until every owed word is out
   task settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task write_csr(logic [2:0] idx, logic [6:0] value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = value;
      @(posedge clock);
      sb.set_reg(idx, value);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task load_geometry(logic [6:0] cols, logic [6:0] rows, logic [6:0] a0, logic [6:0] a1,
                      logic [6:0] a2, logic [6:0] a3, logic [6:0] lit);
      write_csr(CSR_COLUMNS_IN_USE, cols);
      write_csr(CSR_ROWS_IN_USE, rows);
      write_csr(CSR_ROW_ONE_ADDRESS, a0);
      write_csr(CSR_ROW_TWO_ADDRESS, a1);
      write_csr(CSR_ROW_THREE_ADDRESS, a2);
      write_csr(CSR_ROW_FOUR_ADDRESS, a3);
      write_csr(CSR_BACKLIGHT_ON, lit);
      settings_used++;
   endtask

   // mostly text with line control, some noise and dropped codes
   function logic [7:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return CODE_NEWLINE;
      if (r < 13) return CODE_RETURN;
      if (r < 19) return 8'($urandom_range(0, 255));
      if (r < 21) return 8'($urandom_range(0, 9));
      if (r < 23) return 8'($urandom_range(128, 255));
      return 8'($urandom_range(32, 126));
   endfunction

   function logic [6:0] pick_columns();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return 7'd0;
      if (r < 16) return 7'($urandom_range(41, 63));
      if (r < 24) return 7'd40;
      if (r < 40) return 7'($urandom_range(13, 39));
      return 7'($urandom_range(1, 12));
   endfunction

   function logic [6:0] pick_rows();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return 7'd0;
      if (r < 16) return 7'($urandom_range(5, 7));
      return 7'($urandom_range(1, 4));
   endfunction

   initial begin
      int shown;
      logic [7:0] code;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset geometry: dropped codes at both ends, return, text, newlines to a clear
      send_char(8'd0);
      send_char(CODE_LOWEST - 8'd1);
      send_char(CODE_HIGHEST + 8'd1);
      send_char(8'd255);
      send_char(CODE_RETURN);
      send_char("A");
      send_char(CODE_HIGHEST);
      repeat (4) send_char(CODE_NEWLINE);
      settle();

      // no columns or rows: x and newline clear; backlight off; unused index ignored
      write_csr(CSR_COLUMNS_IN_USE, 7'd0);
      write_csr(CSR_ROWS_IN_USE, 7'd0);
      write_csr(CSR_BACKLIGHT_ON, 7'd0);
      write_csr(CSR_UNUSED, 7'h7f);
      settings_used++;
      send_char("x");
      send_char(CODE_NEWLINE);
      send_char(CODE_RETURN);
      settle();

      // counts above their limits, extreme row addresses
      load_geometry(7'd63, 7'd7, 7'd127, 7'd0, 7'd127, 7'd0, 7'd1);
      send_char("a");
      repeat (4) send_char(CODE_NEWLINE);
      send_char("b");
      send_char("c");
      send_char("d");
      send_char("e");
      send_char("f");
      settle();

      // shrink the counts under the cursor: next character takes the clear path
      write_csr(CSR_COLUMNS_IN_USE, 7'd2);
      write_csr(CSR_ROWS_IN_USE, 7'd1);
      settings_used++;
      send_char("g");
      send_char("h");
      settle();

      // random phases, each with its own geometry
      for (int phase = 0; phase < 6; phase++) begin
         calm = (phase == 2);
         load_geometry(pick_columns(), pick_rows(), 7'($urandom_range(0, 127)),
                       7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                       7'($urandom_range(0, 127)), 7'($urandom_range(0, 1)));
         shown = 0;
         while (shown < 47) begin
            code = pick_char();
            send_char(code);
            if (code >= CODE_LOWEST && code <= CODE_HIGHEST) shown++;
         end
         settle();
      end
      calm = 1'b0;

      $display("run: %0d characters (%0d displayable) under %0d register settings",
               sb.chars_seen, sb.chars_shown, settings_used);
      $display("run: %0d expander words checked, %0d mismatches", sb.words_seen, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end
endmodule

// ===== char_lcd_terminal_writer.f =====
rtl/clt_pkg.sv
rtl/clt_decode.sv
rtl/clt_emit.sv
rtl/char_lcd_terminal_writer.sv
verif/tb.sv
